// ===== src/ffsa_pkg.sv =====
// Package for the first-fit segment allocator: constants, codes, entry type.
// No dependencies.
package ffsa_pkg;
	localparam int MAX_SEGMENTS = 64;
	localparam int ID_BITS = 16;
	localparam int KB_W = 31;
	localparam int IDX_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int SEG_W = KB_W + 1 + ID_BITS;
	localparam int QDEPTH = 2;
	localparam logic [KB_W-1:0] DISK_RESET = 31'd1048576;

	typedef enum logic [1:0] {
		REQ_INSERT  = 2'd0,
		REQ_REMOVE  = 2'd1,
		REQ_COMPACT = 2'd2,
		REQ_RESTART = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_TABLE    = 2'd3
	} status_t;

	typedef struct packed {
		logic [KB_W-1:0]    size;
		logic               used;
		logic [ID_BITS-1:0] owner;
	} seg_t;

	typedef struct packed {
		req_t               req;
		logic [ID_BITS-1:0] id;
		logic [KB_W-1:0]    size;
	} cmd_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SCAN_RD, S_SCAN_CHK,
		S_INS_SH_RD, S_INS_SH_WR, S_INS_FIN,
		S_CMP_RD, S_CMP_WR, S_CMP_TAIL,
		S_INS2_RD, S_INS2_CHK,
		S_REM_RD, S_REM_CHK, S_REM_NRD, S_REM_NCHK,
		S_REM_PRD, S_REM_PCHK,
		S_DROP_RD, S_DROP_WR,
		S_DONE
	} state_t;
endpackage

// ===== src/ffsa_if.sv =====
// Valid/ready channel interfaces for the allocator.
// Depends on ffsa_pkg.
interface ffsa_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic [ffsa_pkg::ID_BITS-1:0] file_id;
	logic [ffsa_pkg::KB_W-1:0] size_kb;
	modport source (output valid, req_type, file_id, size_kb, input ready);
	modport sink (input valid, req_type, file_id, size_kb, output ready);
endinterface

interface ffsa_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic [ffsa_pkg::KB_W-1:0]  free_kb;
	logic [ffsa_pkg::CNT_W-1:0] segment_count;
	modport source (output valid, status, free_kb, segment_count, input ready);
	modport sink (input valid, status, free_kb, segment_count, output ready);
endinterface

// ===== src/ffsa_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/ffsa_front.sv =====
// Front end: accepts request transactions, classifies, queues commands.
// Depends on ffsa_pkg and ffsa_if.
module ffsa_front (
	input  logic              clk,
	input  logic              arst_n,
	ffsa_req_if.sink          req,
	output ffsa_pkg::cmd_t    cmd,
	output logic              cmd_valid,
	input  logic              cmd_pop
);
	import ffsa_pkg::*;
	localparam int QW = $clog2(QDEPTH);
	cmd_t           q_q [QDEPTH];
	logic [QW-1:0]  rp_q, wp_q;
	logic [QW:0]    cnt_q;
	logic           push;

	assign req.ready = (cnt_q != (QW+1)'(QDEPTH));
	assign push = req.valid && req.ready;
	assign cmd_valid = (cnt_q != '0);
	assign cmd = q_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (cmd_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q].req <= req_t'(req.req_type);
			q_q[wp_q].id <= req.file_id;
			q_q[wp_q].size <= req.size_kb;
		end
	end
endmodule

// ===== src/ffsa_back.sv =====
// Back end: sequencer that walks and shifts the segment table in RAM.
// Depends on ffsa_pkg, ffsa_ram and ffsa_if.
module ffsa_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ffsa_pkg::KB_W-1:0] cfg_wdata,
	input  ffsa_pkg::cmd_t    cmd,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	ffsa_rsp_if.source        rsp
);
	import ffsa_pkg::*;

	state_t          st_q, st_d;
	cmd_t            c_q, c_d;
	logic [KB_W-1:0] disk_q, free_q, free_d;
	logic            full_q, full_d;
	logic [CNT_W-1:0] tot_q, tot_d;
	logic [CNT_W-1:0] i_q, i_d, k_q, k_d, w_q, w_d;
	seg_t            hold_q, hold_d;
	logic [1:0]      stat_q, stat_d;
	logic            rv_q, rv_d;

	logic            we;
	logic [IDX_W-1:0] waddr, raddr;
	seg_t            wdata, rdata;
	logic [SEG_W-1:0] rdata_raw;

	ffsa_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata_raw)
	);
	assign rdata = seg_t'(rdata_raw);

	assign rsp.valid = rv_q;
	assign rsp.status = stat_q;
	assign rsp.free_kb = free_q;
	assign rsp.segment_count = tot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			disk_q <= DISK_RESET;
			free_q <= DISK_RESET;
			full_q <= 1'b0;
			tot_q <= CNT_W'(1);
			rv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) disk_q <= cfg_wdata;
			free_q <= free_d;
			full_q <= full_d;
			tot_q <= tot_d;
			rv_q <= rv_d;
		end
	end

	always_ff @(posedge clk) begin
		c_q <= c_d;
		i_q <= i_d;
		k_q <= k_d;
		w_q <= w_d;
		hold_q <= hold_d;
		stat_q <= stat_d;
	end

	// entry 0 is the reset free segment until first written
	logic init_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) init_q <= 1'b1;
		else if (we && waddr == '0) init_q <= 1'b0;
	end
	logic [IDX_W-1:0] raddr_s1;
	always_ff @(posedge clk) raddr_s1 <= raddr;
	seg_t rd;
	always_comb begin
		rd = rdata;
		if (init_q && raddr_s1 == '0) rd = '{size: DISK_RESET, used: 1'b0, owner: '0};
	end

	always_comb begin
		st_d = st_q;
		c_d = c_q;
		free_d = free_q;
		full_d = full_q;
		tot_d = tot_q;
		i_d = i_q;
		k_d = k_q;
		w_d = w_q;
		hold_d = hold_q;
		stat_d = stat_q;
		rv_d = rv_q;
		cmd_pop = 1'b0;
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = i_q[IDX_W-1:0];
		if (rv_q && rsp.ready) rv_d = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				if (cmd_valid && !rv_q) begin
					cmd_pop = 1'b1;
					c_d = cmd;
					i_d = '0;
					stat_d = ST_OK;
					priority if (cmd.req == REQ_RESTART) begin
						we = 1'b1;
						wdata = '{size: disk_q, used: 1'b0, owner: '0};
						tot_d = CNT_W'(1);
						free_d = disk_q;
						full_d = 1'b0;
						st_d = S_DONE;
					end else if (full_q) begin
						stat_d = ST_FULL;
						st_d = S_DONE;
					end else if (cmd.req == REQ_INSERT) begin
						if (cmd.size > free_q) begin
							full_d = 1'b1;
							stat_d = ST_FULL;
							st_d = S_DONE;
						end else st_d = S_SCAN_RD;
					end else if (cmd.req == REQ_REMOVE) st_d = S_REM_RD;
					else begin
						w_d = '0;
						st_d = S_CMP_RD;
					end
				end
			end
			S_SCAN_RD: begin
				raddr = i_q[IDX_W-1:0];
				if (i_q >= tot_q) begin
					w_d = '0;
					i_d = '0;
					st_d = S_CMP_RD;
				end else st_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (!rd.used && rd.size >= c_q.size) begin
					if (tot_q >= CNT_W'(MAX_SEGMENTS)) begin
						stat_d = ST_TABLE;
						st_d = S_DONE;
					end else begin
						k_d = i_q;
						hold_d = rd;
						i_d = tot_q;
						st_d = S_INS_SH_RD;
					end
				end else begin
					i_d = i_q + 1'b1;
					st_d = S_SCAN_RD;
				end
			end
			S_INS_SH_RD: begin
				raddr = IDX_W'(i_q - 1'b1);
				if (i_q == k_q + 1'b1) st_d = S_INS_FIN;
				else if (i_q > k_q + 1'b1) st_d = S_INS_SH_WR;
				else st_d = S_INS_FIN;
			end
			S_INS_SH_WR: begin
				we = 1'b1;
				waddr = i_q[IDX_W-1:0];
				wdata = rd;
				i_d = i_q - 1'b1;
				st_d = S_INS_SH_RD;
			end
			S_INS_FIN: begin
				if (i_q == k_q + 1'b1) begin
					we = 1'b1;
					waddr = i_q[IDX_W-1:0];
					wdata = '{size: hold_q.size - c_q.size, used: 1'b0, owner: '0};
					i_d = k_q;
				end else begin
					we = 1'b1;
					waddr = k_q[IDX_W-1:0];
					wdata = '{size: c_q.size, used: 1'b1, owner: c_q.id};
					tot_d = tot_q + 1'b1;
					free_d = free_q - c_q.size;
					st_d = S_DONE;
				end
			end
			S_CMP_RD: begin
				raddr = i_q[IDX_W-1:0];
				if (i_q >= tot_q) st_d = S_CMP_TAIL;
				else st_d = S_CMP_WR;
			end
			S_CMP_WR: begin
				if (rd.used) begin
					we = 1'b1;
					waddr = w_q[IDX_W-1:0];
					wdata = rd;
					w_d = w_q + 1'b1;
				end
				i_d = i_q + 1'b1;
				st_d = S_CMP_RD;
			end
			S_CMP_TAIL: begin
				if (w_q < CNT_W'(MAX_SEGMENTS)) begin
					we = 1'b1;
					waddr = w_q[IDX_W-1:0];
					wdata = '{size: free_q, used: 1'b0, owner: '0};
					tot_d = w_q + 1'b1;
				end else tot_d = w_q;
				if (c_q.req == REQ_INSERT) st_d = S_INS2_RD;
				else st_d = S_DONE;
			end
			S_INS2_RD: begin
				i_d = tot_q - 1'b1;
				raddr = IDX_W'(tot_q - 1'b1);
				st_d = S_INS2_CHK;
			end
			S_INS2_CHK: begin
				if (tot_q != '0 && !rd.used && rd.size >= c_q.size) begin
					if (tot_q >= CNT_W'(MAX_SEGMENTS)) begin
						stat_d = ST_TABLE;
						st_d = S_DONE;
					end else begin
						k_d = i_q;
						hold_d = rd;
						i_d = tot_q;
						st_d = S_INS_SH_RD;
					end
				end else if (tot_q >= CNT_W'(MAX_SEGMENTS)) begin
					stat_d = ST_TABLE;
					st_d = S_DONE;
				end else begin
					full_d = 1'b1;
					stat_d = ST_FULL;
					st_d = S_DONE;
				end
			end
			S_REM_RD: begin
				raddr = i_q[IDX_W-1:0];
				if (i_q >= tot_q) begin
					stat_d = ST_NOTFOUND;
					st_d = S_DONE;
				end else st_d = S_REM_CHK;
			end
			S_REM_CHK: begin
				if (rd.used && rd.owner == c_q.id) begin
					k_d = i_q;
					hold_d = '{size: rd.size, used: 1'b0, owner: '0};
					free_d = free_q + rd.size;
					st_d = S_REM_NRD;
				end else begin
					i_d = i_q + 1'b1;
					st_d = S_REM_RD;
				end
			end
			S_REM_NRD: begin
				raddr = IDX_W'(k_q + 1'b1);
				if (k_q + 1'b1 < tot_q) st_d = S_REM_NCHK;
				else st_d = S_REM_PRD;
			end
			S_REM_NCHK: begin
				if (!rd.used) begin
					hold_d.size = hold_q.size + rd.size;
					i_d = k_q + 1'b1;
					w_d = '0;
					st_d = S_DROP_RD;
				end else st_d = S_REM_PRD;
			end
			S_REM_PRD: begin
				raddr = IDX_W'(k_q - 1'b1);
				if (k_q != '0) st_d = S_REM_PCHK;
				else begin
					we = 1'b1;
					waddr = k_q[IDX_W-1:0];
					wdata = hold_q;
					st_d = S_DONE;
				end
			end
			S_REM_PCHK: begin
				if (!rd.used) begin
					hold_d.size = rd.size + hold_q.size;
					k_d = k_q - 1'b1;
					i_d = k_q;
					w_d = CNT_W'(1);
					st_d = S_DROP_RD;
				end else begin
					we = 1'b1;
					waddr = k_q[IDX_W-1:0];
					wdata = hold_q;
					st_d = S_DONE;
				end
			end
			// remove entry i by shifting down; w_q marks the final pass
			S_DROP_RD: begin
				raddr = IDX_W'(i_q + 1'b1);
				if (i_q + 1'b1 < tot_q) st_d = S_DROP_WR;
				else begin
					tot_d = tot_q - 1'b1;
					if (w_q == '0) st_d = S_REM_PRD;
					else begin
						we = 1'b1;
						waddr = k_q[IDX_W-1:0];
						wdata = hold_q;
						st_d = S_DONE;
					end
				end
			end
			S_DROP_WR: begin
				we = 1'b1;
				waddr = i_q[IDX_W-1:0];
				wdata = rd;
				i_d = i_q + 1'b1;
				st_d = S_DROP_RD;
			end
			S_DONE: begin
				rv_d = 1'b1;
				st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end
endmodule

// ===== src/first_fit_segment_allocator.sv =====
// First-fit segment allocator: 64-entry segment table in one RAM, one result per request.
// Restart and a sticky-full reply need no table walk; walks and shifts read and then check or write
// each entry; the worst case is a failed scan, compaction of 64 entries, then an insert.
// Throughput: one request at a time in the back end; two requests can queue in front.
// Reset: asynchronous, active low; table holds one free segment of 1048576 KB.
// Depends on ffsa_pkg, ffsa_if, ffsa_front, ffsa_back.
module first_fit_segment_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ffsa_pkg::KB_W-1:0] cfg_wdata,
	ffsa_req_if.sink                  req,
	ffsa_rsp_if.source                rsp
);
	import ffsa_pkg::*;
	cmd_t cmd;
	logic cmd_valid, cmd_pop;

	ffsa_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
	);
	ffsa_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .rsp(rsp)
	);
endmodule

// ===== src/ffsa_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
// Depends on ffsa_pkg.
module ffsa_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [1:0] rsp_status,
	input logic [ffsa_pkg::CNT_W-1:0] rsp_count,
	input logic [ffsa_pkg::KB_W-1:0] rsp_free
);
	import ffsa_pkg::*;
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_free)) else $error("rsp dropped");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= CNT_W'(MAX_SEGMENTS)) else $error("count range");
	a_nz: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_OK |-> rsp_count != '0) else $error("empty table");
endmodule

bind first_fit_segment_allocator ffsa_checker u_chk (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_status(rsp.status), .rsp_count(rsp.segment_count), .rsp_free(rsp.free_kb)
);
